@@ rtl/ckrle_pkg.sv @@
// ----------------------------------------------------------------------------
// ckrle_pkg
// Shared types and constants of the color-key run-length sprite encoder.
// ----------------------------------------------------------------------------
package ckrle_pkg;

    localparam int ADDR_W = 13;

    // run header codes
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_OPAQUE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_KEY_COLOR    = 2'd1;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

    // pixel formats
    localparam logic [1:0] FMT_RGB555 = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_RGB888 = 2'd2;
    localparam logic [1:0] FMT_XRGB32 = 2'd3;

    // one pixel's worth of byte writes, as the back sequencer plays it out
    typedef struct packed {
        logic [ADDR_W-1:0]  base;       // write pointer before this pixel
        logic [1:0]         pre;        // alignment zeros ahead of the header
        logic               hdr;        // a new run opens
        logic [1:0]         kind;       // header byte
        logic [2:0]         nbytes;     // packed pixel bytes
        logic [3:0][7:0]    pix;        // pixel bytes, lowest first
        logic [ADDR_W-1:0]  cnt_addr;   // count byte location
        logic [7:0]         cnt_val;    // count byte value
        logic [1:0]         post;       // trailing line zeros
        logic               last;       // closes the line
        logic [ADDR_W-1:0]  len;        // encoded line length
    } desc_t;

    // configuration as seen by the front
    typedef struct packed {
        logic        key_enable;
        logic [23:0] key_color;
        logic [1:0]  pixel_format;
    } cfg_t;

    // bytes per pixel for a format
    function automatic logic [2:0] bytes_of_format(input logic [1:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_RGB555: n = 3'd2;
            FMT_RGB565: n = 3'd2;
            FMT_RGB888: n = 3'd3;
            default:    n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/ckrle_front.sv @@
// ----------------------------------------------------------------------------
// ckrle_front
// Holds configuration and line state, classifies each pixel and turns it into
// a write descriptor for the queue.
// ----------------------------------------------------------------------------
module ckrle_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [23:0]                 cfg_data,
    input  logic                        take,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    input  logic                        line_end,
    output ckrle_pkg::desc_t            desc
);

    ckrle_pkg::cfg_t                    cfg_reg;
    logic [1:0]                         run_kind_reg;
    logic [1:0]                         run_kind_next;
    logic [ckrle_pkg::ADDR_W-1:0]       cnt_addr_reg;
    logic [ckrle_pkg::ADDR_W-1:0]       cnt_addr_next;
    logic [7:0]                         run_count_reg;
    logic [7:0]                         run_count_next;
    logic [ckrle_pkg::ADDR_W-1:0]       wp_reg;
    logic [ckrle_pkg::ADDR_W-1:0]       wp_next;

    logic [2:0]                         bpp;
    logic                               clear;
    logic [1:0]                         kind;
    logic [8:0]                         rc_sum;
    logic                               new_run;
    logic [1:0]                         pre;
    logic [ckrle_pkg::ADDR_W-1:0]       wp_hdr;
    logic [ckrle_pkg::ADDR_W-1:0]       wp_data;
    logic [ckrle_pkg::ADDR_W-1:0]       wp_end;
    logic [ckrle_pkg::ADDR_W-1:0]       cnt_addr;
    logic [7:0]                         cnt_val;
    logic [2:0]                         nbytes;
    logic [1:0]                         post;
    logic [15:0]                        pix16;
    logic [3:0][7:0]                    pix;

    // classify and lay out the writes of this pixel
    always_comb
    begin
        bpp     = ckrle_pkg::bytes_of_format(cfg_reg.pixel_format);
        clear   = cfg_reg.key_enable && ({red, green, blue} == cfg_reg.key_color);
        kind    = clear ? ckrle_pkg::KIND_CLEAR : ckrle_pkg::KIND_OPAQUE;
        rc_sum  = {1'b0, run_count_reg} + {6'd0, bpp};
        new_run = (run_kind_reg != kind) || (rc_sum > 9'd255);
        pre     = (!clear && new_run) ? 2'(2'd2 - wp_reg[1:0]) : 2'd0;
        wp_hdr  = wp_reg + {11'd0, pre};
        cnt_addr = new_run ? wp_hdr + 13'd1 : cnt_addr_reg;
        wp_data = new_run ? wp_hdr + 13'd2 : wp_reg;
        nbytes  = clear ? 3'd0 : bpp;
        wp_end  = wp_data + {10'd0, nbytes};
        post    = line_end ? 2'(2'd0 - wp_end[1:0]) : 2'd0;
        cnt_val = new_run ? {5'd0, bpp} : rc_sum[7:0];
    end

    // pack the pixel bytes
    always_comb
    begin
        pix16 = 16'd0;
        pix   = '0;
        unique case (cfg_reg.pixel_format)
            ckrle_pkg::FMT_RGB555:
            begin
                pix16  = {1'b0, red[7:3], green[7:3], blue[7:3]};
                pix[0] = pix16[7:0];
                pix[1] = pix16[15:8];
            end
            ckrle_pkg::FMT_RGB565:
            begin
                pix16  = {red[7:3], green[7:2], blue[7:3]};
                pix[0] = pix16[7:0];
                pix[1] = pix16[15:8];
            end
            default:
            begin
                pix[0] = blue;
                pix[1] = green;
                pix[2] = red;
            end
        endcase
    end

    // descriptor for the queue
    always_comb
    begin
        desc.base     = wp_reg;
        desc.pre      = pre;
        desc.hdr      = new_run;
        desc.kind     = kind;
        desc.nbytes   = nbytes;
        desc.pix      = pix;
        desc.cnt_addr = cnt_addr;
        desc.cnt_val  = cnt_val;
        desc.post     = post;
        desc.last     = line_end;
        desc.len      = wp_end + {11'd0, post};
    end

    // next line state
    always_comb
    begin
        run_kind_next  = run_kind_reg;
        cnt_addr_next  = cnt_addr_reg;
        run_count_next = run_count_reg;
        wp_next        = wp_reg;
        if (take)
        begin
            if (line_end)
            begin
                run_kind_next  = ckrle_pkg::KIND_NONE;
                cnt_addr_next  = '0;
                run_count_next = '0;
                wp_next        = '0;
            end
            else
            begin
                run_kind_next  = kind;
                cnt_addr_next  = cnt_addr;
                run_count_next = cnt_val;
                wp_next        = wp_end;
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg  <= ckrle_pkg::KIND_NONE;
            cnt_addr_reg  <= '0;
            run_count_reg <= '0;
            wp_reg        <= '0;
        end
        else
        begin
            run_kind_reg  <= run_kind_next;
            cnt_addr_reg  <= cnt_addr_next;
            run_count_reg <= run_count_next;
            wp_reg        <= wp_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_enable   <= 1'b0;
            cfg_reg.key_color    <= 24'd0;
            cfg_reg.pixel_format <= ckrle_pkg::FMT_XRGB32;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ckrle_pkg::CFG_KEY_ENABLE:   cfg_reg.key_enable   <= cfg_data[0];
                ckrle_pkg::CFG_KEY_COLOR:    cfg_reg.key_color    <= cfg_data;
                ckrle_pkg::CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

endmodule

@@ rtl/ckrle_queue.sv @@
// ----------------------------------------------------------------------------
// ckrle_queue
// Small descriptor queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module ckrle_queue
#(
    parameter int DEPTH = 4     // two or more
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ckrle_pkg::desc_t    push_data,
    input  logic                pop,
    output ckrle_pkg::desc_t    head,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ckrle_pkg::desc_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/ckrle_back.sv @@
// ----------------------------------------------------------------------------
// ckrle_back
// Plays one descriptor out as byte writes, one per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module ckrle_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ckrle_pkg::desc_t                head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ckrle_pkg::ADDR_W-1:0]    byte_address,
    output logic [7:0]                      byte_value,
    output logic                            last_of_item,
    output logic                            line_done,
    output logic [ckrle_pkg::ADDR_W-1:0]    line_length
);

    typedef enum logic [4:0] {
        PH_PRE  = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_PIX  = 5'b00100,
        PH_CNT  = 5'b01000,
        PH_POST = 5'b10000
    } phase_t;

    logic                           start_reg;
    logic                           start_next;
    phase_t                         phase_reg;
    phase_t                         phase_next;
    logic [ckrle_pkg::ADDR_W-1:0]   addr_reg;
    logic [ckrle_pkg::ADDR_W-1:0]   addr_next;
    logic [2:0]                     sub_reg;
    logic [2:0]                     sub_next;
    logic                           out_valid_reg;

    phase_t                         cur_phase;
    logic [ckrle_pkg::ADDR_W-1:0]   cur_addr;
    logic [2:0]                     cur_sub;
    logic [2:0]                     sub_inc;
    logic                           step;
    logic                           final_c;
    logic [ckrle_pkg::ADDR_W-1:0]   wr_addr;
    logic [7:0]                     wr_val;

    assign step      = !empty && (!out_valid_reg || !out_stall);
    assign pop       = step && final_c;
    assign out_valid = out_valid_reg;

    // where this step stands: a fresh descriptor starts from its first phase
    always_comb
    begin
        if (start_reg)
        begin
            cur_addr = head.base;
            cur_sub  = 3'd0;
            if (head.pre != 2'd0)
                cur_phase = PH_PRE;
            else if (head.hdr)
                cur_phase = PH_HDR;
            else if (head.nbytes != 3'd0)
                cur_phase = PH_PIX;
            else
                cur_phase = PH_CNT;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_addr  = addr_reg;
            cur_sub   = sub_reg;
        end
    end

    // byte of this step and the step after it
    always_comb
    begin
        sub_inc    = cur_sub + 3'd1;
        wr_addr    = cur_addr;
        wr_val     = 8'd0;
        final_c    = 1'b0;
        phase_next = cur_phase;
        addr_next  = cur_addr + 13'd1;
        sub_next   = sub_inc;
        unique case (cur_phase)
            PH_PRE:
            begin
                if (sub_inc == {1'b0, head.pre})
                begin
                    phase_next = PH_HDR;
                    sub_next   = 3'd0;
                end
            end
            PH_HDR:
            begin
                wr_val     = {6'd0, head.kind};
                addr_next  = cur_addr + 13'd2;
                sub_next   = 3'd0;
                phase_next = (head.nbytes != 3'd0) ? PH_PIX : PH_CNT;
            end
            PH_PIX:
            begin
                wr_val = head.pix[cur_sub[1:0]];
                if (sub_inc == head.nbytes)
                begin
                    phase_next = PH_CNT;
                    sub_next   = 3'd0;
                end
            end
            PH_CNT:
            begin
                wr_addr    = head.cnt_addr;
                wr_val     = head.cnt_val;
                addr_next  = cur_addr;
                sub_next   = 3'd0;
                phase_next = PH_POST;
                final_c    = (head.post == 2'd0);
            end
            PH_POST:
            begin
                final_c = (sub_inc == {1'b0, head.post});
            end
            default:
            begin
                final_c = 1'b1;
            end
        endcase
        start_next = final_c;
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            phase_reg <= PH_PRE;
            addr_reg  <= '0;
            sub_reg   <= '0;
        end
        else if (step)
        begin
            start_reg <= start_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            sub_reg   <= sub_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_address <= wr_addr;
            byte_value   <= wr_val;
            last_of_item <= final_c;
            line_done    <= final_c && head.last;
            line_length  <= (final_c && head.last) ? head.len : '0;
        end
    end

endmodule

@@ rtl/color_key_rle_sprite_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// color_key_rle_sprite_encoder_unit
// Color-keyed run-length sprite line encoder, top level.
// ----------------------------------------------------------------------------
// Pixels come in one per transfer and leave as byte writes into a line
// buffer, one write per cycle while the output is not stalled. A pixel
// writes its pixel bytes (2, 3 or 4 when opaque, none when transparent) plus
// the count byte, plus up to four on a run start (alignment zeros and header)
// and up to three trailing zeros on the last pixel of a line, so 1 to 9
// writes; a 32-bit opaque pixel inside a run writes 5. The front accepts a
// pixel in every cycle while the descriptor queue (QUEUE_DEPTH entries) has
// room, so short bursts of pixels are taken at full rate while writes drain.
module color_key_rle_sprite_encoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            line_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ckrle_pkg::ADDR_W-1:0]    byte_address,
    output logic [7:0]                      byte_value,
    output logic                            last_of_item,
    output logic                            line_done,
    output logic [ckrle_pkg::ADDR_W-1:0]    line_length
);

    ckrle_pkg::desc_t   push_desc;
    ckrle_pkg::desc_t   head;
    logic               full;
    logic               empty;
    logic               pop;
    logic               take;

    // input transfer
    assign in_stall = full;
    assign take     = in_valid && !full;

    ckrle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .line_end   (line_end),
        .desc       (push_desc)
    );

    ckrle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_data  (push_desc),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    ckrle_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_address   (byte_address),
        .byte_value     (byte_value),
        .last_of_item   (last_of_item),
        .line_done      (line_done),
        .line_length    (line_length)
    );

endmodule

@@ rtl/ckrle_checker.sv @@
// ----------------------------------------------------------------------------
// ckrle_checker
// Port-level checks of the encoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module ckrle_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        last_of_item,
    input  logic        line_done,
    input  logic [12:0] line_length
);

    // a stalled write stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output write dropped under stall");

    // the line closes on a pixel's final write
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> last_of_item)
        else $error("line done without last of item");

    // length shows only on the closing write
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> line_length == 13'd0)
        else $error("line length outside line done");

    // encoded line is padded to whole words
    a_len_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> line_length[1:0] == 2'd0)
        else $error("line length not a multiple of four");

endmodule

bind color_key_rle_sprite_encoder_unit ckrle_checker u_ckrle_checker (.*);

@@ bench/color_key_rle_sprite_encoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_key_rle_sprite_encoder_unit_test
// Self-checking bench for the color-keyed run-length sprite line encoder.
// Pixels go in through a valid/stall channel, and every byte write that
// comes out is checked in order against a line encoder kept in the bench.
// The run covers a directed set of pixels, one opaque line long enough to
// split its run, then random lines under three idling patterns and changing
// register settings.
// ----------------------------------------------------------------------------
module color_key_rle_sprite_encoder_unit_test;

    // one pixel waiting to be sent
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       le;
        logic       hold;   // wait until the encoder has drained
    } pixel_t;

    // one byte write into the line buffer
    typedef struct packed {
        logic [ckrle_pkg::ADDR_W-1:0] addr;
        logic [7:0]                   value;
        logic                         last_item;
        logic                         done;
        logic [ckrle_pkg::ADDR_W-1:0] len;
    } byte_write_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [1:0]                   cfg_index = ckrle_pkg::CFG_KEY_ENABLE;
    logic [23:0]                  cfg_data = 24'd0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   red = 8'd0;
    logic [7:0]                   green = 8'd0;
    logic [7:0]                   blue = 8'd0;
    logic                         line_end = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ckrle_pkg::ADDR_W-1:0] byte_address;
    logic [7:0]                   byte_value;
    logic                         last_of_item;
    logic                         line_done;
    logic [ckrle_pkg::ADDR_W-1:0] line_length;

    // bench copy of the registers
    logic                         key_on = 1'b0;
    logic [23:0]                  key_rgb = 24'd0;
    logic [1:0]                   fmt = ckrle_pkg::FMT_XRGB32;

    // bench copy of the line state
    logic [1:0]                   open_kind = ckrle_pkg::KIND_NONE;
    logic [ckrle_pkg::ADDR_W-1:0] count_addr = '0;
    logic [7:0]                   run_bytes = 8'd0;
    logic [ckrle_pkg::ADDR_W-1:0] wr_ptr = '0;

    pixel_t            pixel_queue[$];
    byte_write_t       pending_writes[$];
    int                pixels_sent = 0;
    int                pixels_taken = 0;
    int                error_count = 0;
    int                line_left = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              pixel_accepted = 1'b0;

    color_key_rle_sprite_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .last_of_item (last_of_item),
        .line_done    (line_done),
        .line_length  (line_length)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // queue one expected write
    function automatic void put_byte(input logic [ckrle_pkg::ADDR_W-1:0] addr,
                                     input logic [7:0] value);
        byte_write_t w;
        w.addr      = addr;
        w.value     = value;
        w.last_item = 1'b0;
        w.done      = 1'b0;
        w.len       = '0;
        pending_writes.push_back(w);
    endfunction

    // expected write at the write pointer, then advance it
    function automatic void put_next(input logic [7:0] value);
        put_byte(wr_ptr, value);
        wr_ptr = wr_ptr + 1'b1;
    endfunction

    // encode one accepted pixel into its byte writes
    function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic le);
        int          bpp;
        logic        clear;
        logic [1:0]  kind;
        logic [15:0] pix16;
        byte_write_t w;
        case (fmt)
            ckrle_pkg::FMT_RGB888: bpp = 3;
            ckrle_pkg::FMT_XRGB32: bpp = 4;
            default:               bpp = 2;
        endcase
        clear = key_on && ({r, g, b} == key_rgb);
        kind  = clear ? ckrle_pkg::KIND_CLEAR : ckrle_pkg::KIND_OPAQUE;

        // new run: alignment zeros for opaque data, header, count slot
        if (open_kind != kind || int'(run_bytes) > 255 - bpp)
        begin
            if (!clear)
                while (wr_ptr[1:0] != 2'd2)
                    put_next(8'h00);
            put_next({6'd0, kind});
            open_kind  = kind;
            count_addr = wr_ptr;
            wr_ptr     = wr_ptr + 1'b1;
            run_bytes  = 8'd0;
        end
        run_bytes = 8'(int'(run_bytes) + bpp);

        // packed pixel bytes, low byte first
        if (!clear)
        begin
            case (fmt)
                ckrle_pkg::FMT_RGB555:
                begin
                    pix16 = {1'b0, r[7:3], g[7:3], b[7:3]};
                    put_next(pix16[7:0]);
                    put_next(pix16[15:8]);
                end
                ckrle_pkg::FMT_RGB565:
                begin
                    pix16 = {r[7:3], g[7:2], b[7:3]};
                    put_next(pix16[7:0]);
                    put_next(pix16[15:8]);
                end
                ckrle_pkg::FMT_RGB888:
                begin
                    put_next(b);
                    put_next(g);
                    put_next(r);
                end
                default:
                begin
                    put_next(b);
                    put_next(g);
                    put_next(r);
                    put_next(8'h00);
                end
            endcase
        end

        // count rewrite
        put_byte(count_addr, run_bytes);

        // line close: pad to 4 bytes
        if (le)
            while (wr_ptr[1:0] != 2'd0)
                put_next(8'h00);

        w = pending_writes.pop_back();
        w.last_item = 1'b1;
        if (le)
        begin
            w.done    = 1'b1;
            w.len     = wr_ptr;
            open_kind = ckrle_pkg::KIND_NONE;
            count_addr = '0;
            run_bytes = 8'd0;
            wr_ptr    = '0;
        end
        pending_writes.push_back(w);
    endfunction

    // add a pixel to the send queue
    function automatic void add_pixel(input logic [23:0] rgb, input logic le,
                                      input logic hold);
        pixel_t p;
        p.r    = rgb[23:16];
        p.g    = rgb[15:8];
        p.b    = rgb[7:0];
        p.le   = le;
        p.hold = hold;
        pixel_queue.push_back(p);
        pixels_sent++;
    endfunction

    // random lines built from runs of like pixels
    function automatic void add_random_pixels(input int count);
        int          n;
        int          seg_len;
        int          bpp;
        logic        seg_clear;
        logic [23:0] rgb;
        n = 0;
        bpp = (fmt == ckrle_pkg::FMT_XRGB32) ? 4 : (fmt == ckrle_pkg::FMT_RGB888) ? 3 : 2;
        while (n < count)
        begin
            seg_clear = key_on && ($urandom_range(0, 99) < 40);
            // now and then a long run of like pixels
            if ($urandom_range(0, 29) == 0)
                seg_len = 256 / bpp + int'($urandom_range(0, 4));
            else
                seg_len = int'($urandom_range(1, 6));
            if (seg_len > count - n)
                seg_len = count - n;
            repeat (seg_len)
            begin
                if (seg_clear)
                    rgb = key_rgb;
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       rgb = 24'h000000;
                        1:       rgb = 24'hffffff;
                        2:       rgb = key_rgb ^ (24'h1 << $urandom_range(0, 23));
                        default: rgb = 24'($urandom_range(0, 24'hffffff));
                    endcase
                end
                if (line_left == 0)
                    line_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(80, 200))
                                                            : int'($urandom_range(1, 24));
                line_left--;
                add_pixel(rgb, line_left == 0, $urandom_range(0, 49) == 0);
                n++;
            end
        end
    endfunction

    // register write, mirrored into the bench copy
    task automatic write_reg(input logic [1:0] index, input logic [23:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            ckrle_pkg::CFG_KEY_ENABLE: key_on = data[0];
            ckrle_pkg::CFG_KEY_COLOR:  key_rgb = data;
            default:                   fmt = data[1:0];
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait until every pixel is taken and every write has come out
    task automatic wait_idle;
        while (pixels_taken != pixels_sent || pending_writes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // pixel driver
    always @(negedge clk)
    begin : drive_pixels
        pixel_t px;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || pixel_accepted)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                && (!pixel_queue[0].hold || pending_writes.size() == 0))
            begin
                px = pixel_queue.pop_front();
                red      <= px.r;
                green    <= px.g;
                blue     <= px.b;
                line_end <= px.le;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        pixel_accepted = 1'b0;
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // write checker and pixel capture
    always @(posedge clk)
    begin : check_writes
        byte_write_t got;
        byte_write_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {byte_address, byte_value, last_of_item, line_done, line_length};
                if (pending_writes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected write expected none, actual %0d %02h %b %b %0d",
                             $time, got.addr, got.value, got.last_item, got.done, got.len);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: write expected %0d %02h %b %b %0d, actual %0d %02h %b %b %0d",
                                 $time, want.addr, want.value, want.last_item, want.done,
                                 want.len, got.addr, got.value, got.last_item, got.done,
                                 got.len);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pixel_accepted = 1'b1;
                pixels_taken++;
                encode_pixel(red, green, blue, line_end);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          mode;
        int          k;
        logic [23:0] color;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 79;

        // reset settings: keying off, so black stays opaque
        add_pixel(24'h000000, 1'b0, 1'b0);
        add_pixel(24'hffffff, 1'b0, 1'b0);
        add_pixel(24'h000000, 1'b1, 1'b0);
        wait_idle;

        // 15-bit, white keyed, line opens and closes transparent
        write_reg(ckrle_pkg::CFG_KEY_ENABLE, 24'd1);
        write_reg(ckrle_pkg::CFG_KEY_COLOR, 24'hffffff);
        write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, ckrle_pkg::FMT_RGB555});
        add_pixel(24'hffffff, 1'b0, 1'b0);
        add_pixel(24'hffffff, 1'b0, 1'b0);
        add_pixel(24'h804020, 1'b0, 1'b1);
        add_pixel(24'hfffeff, 1'b0, 1'b0);
        add_pixel(24'hffffff, 1'b1, 1'b0);
        wait_idle;

        // 16-bit, black keyed, single-pixel transparent line
        write_reg(ckrle_pkg::CFG_KEY_COLOR, 24'h000000);
        write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, ckrle_pkg::FMT_RGB565});
        add_pixel(24'h000000, 1'b1, 1'b0);
        add_pixel(24'hffffff, 1'b0, 1'b0);
        add_pixel(24'ha55ac3, 1'b1, 1'b0);
        wait_idle;

        // 24-bit, line left open across a format change
        write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, ckrle_pkg::FMT_RGB888});
        add_pixel(24'h123456, 1'b0, 1'b0);
        add_pixel(24'h000000, 1'b0, 1'b0);
        add_pixel(24'hff00ff, 1'b0, 1'b0);
        add_pixel(24'h010203, 1'b1, 1'b0);
        add_pixel(24'h7f8081, 1'b0, 1'b0);
        wait_idle;
        write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, ckrle_pkg::FMT_RGB555});
        add_pixel(24'hfedcba, 1'b0, 1'b0);
        add_pixel(24'h000000, 1'b0, 1'b0);
        add_pixel(24'h0f0f0f, 1'b1, 1'b0);
        wait_idle;

        // keying off with the key color still set; the run splits past 255 bytes
        write_reg(ckrle_pkg::CFG_KEY_ENABLE, 24'd0);
        write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, ckrle_pkg::FMT_XRGB32});
        for (k = 0; k < 66; k++)
            add_pixel((k < 2) ? 24'h000000 : 24'($urandom_range(0, 24'hffffff)),
                      k == 65, 1'b0);
        wait_idle;

        // random lines, settings changed between phases, often mid-line
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 79 : 0;
            recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 38 : 0;
            for (k = 0; k < 4; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       color = 24'h000000;
                    1:       color = 24'hffffff;
                    default: color = 24'($urandom_range(0, 24'hffffff));
                endcase
                write_reg(ckrle_pkg::CFG_KEY_ENABLE, {23'd0, $urandom_range(0, 3) != 0});
                write_reg(ckrle_pkg::CFG_KEY_COLOR, color);
                write_reg(ckrle_pkg::CFG_PIXEL_FORMAT, {22'd0, 2'(k + mode)});
                add_random_pixels(25);
                wait_idle;
            end
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("color_key_rle_sprite_encoder_unit: match");
        else
            $display("color_key_rle_sprite_encoder_unit: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("color_key_rle_sprite_encoder_unit: mismatch");
        $finish;
    end

endmodule
